/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the polar to Cartesian converter.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle in which an antecedent holds.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/core/p2c_pkg.sv */
// Package for the polar to Cartesian converter: widths, constants, the word type
// handed along the rotation chain and the arctangent table. It depends on nothing.
package p2c_pkg;

   localparam int ROTATION_STEPS = 16;
   localparam int TABLE_LEN      = 24;

   localparam int MAG_W   = 16;
   localparam int ANG_W   = 16;
   localparam int OUT_W   = 17;
   localparam int RED_W   = 15;
   localparam int QUO_W   = 9;
   localparam int REM_W   = 6;
   localparam int PHASE_W = 32;
   localparam int XY_W    = 34;
   localparam int Z_W     = 33;
   localparam int GAIN_W  = 30;

   localparam int TURN_UNITS = 23040;
   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
   // Reciprocal of 45 scaled by 2^21, exact for any reduced angle.
   localparam logic [15:0] RECIP45 = 16'd46604;
   localparam int RECIP45_SHIFT = 21;
   // Integer part of 2^23 / 45.
   localparam logic [17:0] PHASE_PER_REM = 18'd186413;
   localparam int OUT_LIMIT = 65535;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } vec_type;

   function automatic logic [PHASE_W-1:0] atan_of(input int idx);
      logic [PHASE_W-1:0] a;
      case (idx)
         0:  a = 32'd536870912;
         1:  a = 32'd316933406;
         2:  a = 32'd167458907;
         3:  a = 32'd85004756;
         4:  a = 32'd42667331;
         5:  a = 32'd21354465;
         6:  a = 32'd10679838;
         7:  a = 32'd5340245;
         8:  a = 32'd2670163;
         9:  a = 32'd1335087;
         10: a = 32'd667544;
         11: a = 32'd333772;
         12: a = 32'd166886;
         13: a = 32'd83443;
         14: a = 32'd41722;
         15: a = 32'd20861;
         16: a = 32'd10430;
         17: a = 32'd5215;
         18: a = 32'd2608;
         19: a = 32'd1304;
         20: a = 32'd652;
         21: a = 32'd326;
         22: a = 32'd163;
         23: a = 32'd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* rtl/core/p2c_front.sv */
// Front end of the polar to Cartesian converter: angle reduction, phase mapping,
// half-turn fold and gain-compensated start vector, in three stages. Uses p2c_pkg.
module p2c_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [p2c_pkg::MAG_W-1:0]      magnitude,
   input  logic signed [p2c_pkg::ANG_W-1:0] angle_deg,
   output logic                           out_valid,
   input  logic                           out_ready,
   output p2c_pkg::vec_type               out_vec
);

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   logic [p2c_pkg::RED_W-1:0]   red1_ff, red1_in, red2_ff;
   logic [p2c_pkg::XY_W-1:0]    x1_ff, x1_in, x2_ff;
   logic [p2c_pkg::QUO_W-1:0]   q2_ff, q2_in;
   p2c_pkg::vec_type            vec3_ff, vec3_in;

   logic signed [p2c_pkg::ANG_W:0]  ang_s, red_s;
   logic [p2c_pkg::MAG_W+p2c_pkg::GAIN_W-1:0] gain_prod;
   logic [p2c_pkg::RED_W+15:0]      q_prod;
   logic [p2c_pkg::RED_W-1:0]       q_times;
   logic [p2c_pkg::RED_W-1:0]       rem_full;
   logic [p2c_pkg::REM_W-1:0]       rem;
   logic [p2c_pkg::PHASE_W-1:0]     frac, phase;
   logic                            flip;

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      ang_s = {angle_deg[p2c_pkg::ANG_W-1], angle_deg};
      if (ang_s < -17'sd23040) begin
         red_s = ang_s + 17'sd46080;
      end else if (ang_s < 17'sd0) begin
         red_s = ang_s + 17'sd23040;
      end else if (ang_s >= 17'sd23040) begin
         red_s = ang_s - 17'sd23040;
      end else begin
         red_s = ang_s;
      end
      red1_in = red_s[p2c_pkg::RED_W-1:0];
      gain_prod = {{p2c_pkg::GAIN_W{1'b0}}, magnitude} *
                  {{p2c_pkg::MAG_W{1'b0}}, p2c_pkg::GAIN_Q30};
      x1_in = {2'b00, gain_prod[45:14]};
   end

   always_comb begin
      q_prod = {16'd0, red1_ff} * {15'd0, p2c_pkg::RECIP45};
      q2_in = q_prod[p2c_pkg::RECIP45_SHIFT +: p2c_pkg::QUO_W];
   end

   // The remainder's share of the phase is 186413 * rem + ceil(rem / 2) for rem below 45.
   always_comb begin
      q_times  = {6'd0, q2_ff} * 15'd45;
      rem_full = red2_ff - q_times;
      rem      = rem_full[p2c_pkg::REM_W-1:0];
      frac     = {26'd0, rem} * {14'd0, p2c_pkg::PHASE_PER_REM}
               + {26'd0, (rem + 6'd1) >> 1};
      phase    = {q2_ff, 23'd0} + frac;
      flip     = phase[31] ^ phase[30];
      vec3_in.x    = x2_ff;
      vec3_in.y    = '0;
      vec3_in.z    = {phase[31] ^ flip, phase[31] ^ flip, phase[30:0]};
      vec3_in.flip = flip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         red1_ff <= red1_in;
         x1_ff   <= x1_in;
      end
      if (rdy2) begin
         red2_ff <= red1_ff;
         x2_ff   <= x1_ff;
         q2_ff   <= q2_in;
      end
      if (rdy3) begin
         vec3_ff <= vec3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_vec   = vec3_ff;

endmodule

/* rtl/core/p2c_cell.sv */
// One micro-rotation cell of the converter's CORDIC chain, with its own register
// and handshake toward its neighbors. Uses p2c_pkg.
module p2c_cell #(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  p2c_pkg::vec_type in_vec,
   output logic             out_valid,
   input  logic             out_ready,
   output p2c_pkg::vec_type out_vec
);

   localparam logic signed [p2c_pkg::Z_W-1:0] ATAN =
      $signed({1'b0, p2c_pkg::atan_of(IDX)});

   logic             valid_ff;
   p2c_pkg::vec_type vec_ff, vec_in;
   logic signed [p2c_pkg::XY_W-1:0] dx, dy;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      dx = in_vec.y >>> IDX;
      dy = in_vec.x >>> IDX;
      vec_in.flip = in_vec.flip;
      if (!in_vec.z[p2c_pkg::Z_W-1]) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ATAN;
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

/* rtl/core/p2c_output.sv */
// Output stage of the converter: rounds to 8 fraction bits, undoes the half-turn
// fold, saturates and holds the result word for the receiver. Uses p2c_pkg.
module p2c_output (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  p2c_pkg::vec_type                 in_vec,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [p2c_pkg::OUT_W-1:0] real_part,
   output logic signed [p2c_pkg::OUT_W-1:0] imag_part
);

   logic valid_ff;
   logic signed [p2c_pkg::OUT_W-1:0] re_ff, re_in, im_ff, im_in;

   function automatic logic signed [p2c_pkg::OUT_W-1:0] finish(
      input logic signed [p2c_pkg::XY_W-1:0] v,
      input logic                            flip
   );
      logic signed [p2c_pkg::XY_W:0] rounded;
      logic signed [18:0]            scaled;
      logic signed [19:0]            signed_v;
      logic signed [p2c_pkg::OUT_W-1:0] r;
      rounded  = {v[p2c_pkg::XY_W-1], v} + 35'sd32768;
      scaled   = rounded[p2c_pkg::XY_W:16];
      signed_v = flip ? -{scaled[18], scaled} : {scaled[18], scaled};
      if (signed_v > 20'sd65535) begin
         r = 17'sd65535;
      end else if (signed_v < -20'sd65535) begin
         r = -17'sd65535;
      end else begin
         r = signed_v[p2c_pkg::OUT_W-1:0];
      end
      return r;
   endfunction

   assign in_ready = !valid_ff || out_ready;
   assign re_in = finish(in_vec.x, in_vec.flip);
   assign im_in = finish(in_vec.y, in_vec.flip);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign out_valid = valid_ff;
   assign real_part = re_ff;
   assign imag_part = im_ff;

endmodule

/* rtl/core/polar_to_cartesian.sv */
// Polar to Cartesian converter: turns a magnitude and an angle into x and y.
// Depends on p2c_pkg, p2c_front, p2c_cell, p2c_output and assert_macros.svh.
//
// The req channel carries one word per request: an unsigned Q8.8 magnitude and a
// signed angle in 1/64 degree, any turn. The rsp channel returns one word per
// request, in order: magnitude times cosine and magnitude times sine, signed with
// 8 fraction bits and saturated to plus or minus 65535.
// The datapath is a three-stage front end (angle reduction, phase mapping and
// start vector), a chain of ROTATION_STEPS rotation cells and a rounding stage.
// Throughput is one word per cycle while the receiver does not stall; each stage holds its own register.
// Every stage has a valid bit and moves when the stage after it is empty or
// moving, so bubbles close up and a stalled receiver fills the chain before
// req_tready drops; the chain then holds ROTATION_STEPS + 4 words.
// A synchronous reset clears all valid bits, leaving the chain empty.
`include "assert_macros.svh"

module polar_to_cartesian #(
   parameter int ROTATION_STEPS = p2c_pkg::ROTATION_STEPS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // magnitude [15:0], angle_deg [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // real_part [16:0], imag_part [33:17], zeros above
);

   p2c_pkg::vec_type vec   [ROTATION_STEPS+1];
   logic             valid [ROTATION_STEPS+1];
   logic             ready [ROTATION_STEPS+1];
   logic signed [p2c_pkg::OUT_W-1:0] real_part, imag_part;

   p2c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .magnitude (req_tdata[15:0]),
      .angle_deg ($signed(req_tdata[31:16])),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_vec   (vec[0])
   );

   for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_cell
      p2c_cell #(
         .IDX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[k]),
         .in_ready  (ready[k]),
         .in_vec    (vec[k]),
         .out_valid (valid[k+1]),
         .out_ready (ready[k+1]),
         .out_vec   (vec[k+1])
      );
   end

   p2c_output u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[ROTATION_STEPS]),
      .in_ready  (ready[ROTATION_STEPS]),
      .in_vec    (vec[ROTATION_STEPS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .real_part (real_part),
      .imag_part (imag_part)
   );

   assign rsp_tdata = {6'd0, imag_part, real_part};

   `ASSERT_IMPLY(a_stall_only_when_full, !req_tready, rsp_tvalid && !rsp_tready, "early stall")
   `ASSERT_IMPLY(a_drain_frees_input, rsp_tvalid && rsp_tready, req_tready, "input stuck")
   `ASSERT_IMPLY(a_sat, rsp_tvalid, real_part != 17'h10000 && imag_part != 17'h10000, "overflow")
   `ASSERT_IMPLY(a_empty_after_reset, $past(reset), !rsp_tvalid, "word after reset")

endmodule
